// ----- sv/dmc_pkg.sv -----
// Shared types and constants for the direct-mapped write-through cache.
package dmc_pkg;

  // Geometry of main memory and the cache.
  localparam int MEM_WORDS   = 1024;
  localparam int CACHE_WORDS = 64;
  localparam int BLOCK_WORDS = 4;
  localparam int LINE_COUNT  = CACHE_WORDS / BLOCK_WORDS;

  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int WORD_W = $clog2(BLOCK_WORDS);
  localparam int LINE_W = $clog2(LINE_COUNT);
  localparam int SLOT_W = $clog2(CACHE_WORDS);
  localparam int TAG_W  = ADDR_W - SLOT_W;
  localparam int FILL_W = WORD_W + 1;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  // Write request into main memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// ----- sv/dmc_main_mem.sv -----
// Main memory with a clearing pass after reset that loads each word's reset value.
module dmc_main_mem
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  output logic              busy
);

  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [ADDR_W:0]   clr_cnt_r;
  logic [DATA_W-1:0] rdata_r;

  assign busy  = (clr_cnt_r != (ADDR_W+1)'(MEM_WORDS));
  assign rdata = rdata_r;

  // Sweep counter for the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Write port: the clearing pass has priority, then normal writes.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt_r[ADDR_W-1:0]] <= DATA_W'(MEM_WORDS) - DATA_W'(clr_cnt_r);
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ----- sv/direct_mapped_cache_write_through_top.sv -----
// Direct-mapped write-through, write-allocate cache in front of main memory.
// One access at a time; a miss fill reads one word per cycle from main memory.
// The next word is accepted while a finished result still waits on the output.
// After reset a clearing pass loads all MEM_WORDS (1024) words of main memory;
// no word is accepted during it. All cache lines start invalid.
module direct_mapped_cache_write_through_top
  import dmc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [ADDR_W-1:0]        in_address,
  input  logic signed [DATA_W-1:0] in_write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_miss,
  output logic [WORD_W-1:0]        out_word_index,
  output logic [LINE_W-1:0]        out_line_index,
  output logic [TAG_W-1:0]         out_tag_out,
  output logic signed [DATA_W-1:0] out_data_out
);

  state_t state_r, state_nxt;

  // Accepted access.
  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] wval_r;
  logic              miss_r;
  logic [FILL_W-1:0] fill_cnt_r;
  logic [DATA_W-1:0] fill_word_r;

  // Line state.
  logic [LINE_COUNT-1:0] valid_r;
  logic [TAG_W-1:0]      tag_r [LINE_COUNT];

  // Cache data memory.
  logic [DATA_W-1:0] cache_mem [CACHE_WORDS];
  logic [DATA_W-1:0] cache_rdata_r;

  // Output register.
  logic              out_valid_r;
  logic              out_miss_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;

  // Control outputs of the state machine.
  logic              res_go;
  logic [SLOT_W-1:0] cache_raddr;
  logic              cache_we;
  logic [SLOT_W-1:0] cache_waddr;
  logic [DATA_W-1:0] cache_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  mem_wr_t           mem_wr;
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_busy;
  logic [FILL_W-1:0] fill_prev;
  logic              fill_last;

  // Address split of the incoming and the held access.
  logic [LINE_W-1:0] in_line;
  logic [TAG_W-1:0]  in_tag;
  logic              in_hit;
  logic [LINE_W-1:0] cur_line;
  logic [WORD_W-1:0] cur_word;
  logic [TAG_W-1:0]  cur_tag;

  assign in_line  = in_address[SLOT_W-1:WORD_W];
  assign in_tag   = in_address[ADDR_W-1:SLOT_W];
  assign in_hit   = valid_r[in_line] && (tag_r[in_line] == in_tag);
  assign cur_line = addr_r[SLOT_W-1:WORD_W];
  assign cur_word = addr_r[WORD_W-1:0];
  assign cur_tag  = addr_r[ADDR_W-1:SLOT_W];

  assign fill_prev = fill_cnt_r - 1'b1;
  assign fill_last = (fill_cnt_r == FILL_W'(BLOCK_WORDS));

  dmc_main_mem u_main_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (!mem_busy) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = in_hit ? ST_RESP : ST_FILL;
      end
      ST_FILL: begin
        if (fill_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    in_ready     = 1'b0;
    res_go       = 1'b0;
    cache_raddr  = addr_r[SLOT_W-1:0];
    cache_we     = 1'b0;
    cache_waddr  = addr_r[SLOT_W-1:0];
    cache_wdata  = wval_r;
    mem_raddr    = {addr_r[ADDR_W-1:WORD_W], fill_cnt_r[WORD_W-1:0]};
    mem_wr.we    = 1'b0;
    mem_wr.addr  = addr_r;
    mem_wr.data  = wval_r;
    case (state_r)
      ST_CLEAR: begin
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cache_raddr = in_address[SLOT_W-1:0];
      end
      ST_FILL: begin
        // Word fill_cnt-1 returns from main memory this cycle.
        if (fill_cnt_r != '0) begin
          cache_we    = 1'b1;
          cache_waddr = {cur_line, fill_prev[WORD_W-1:0]};
          cache_wdata = mem_rdata;
        end
      end
      ST_RESP: begin
        res_go = !out_valid_r || out_ready;
        if (res_go && (cmd_r == CMD_WRITE)) begin
          cache_we  = 1'b1;
          mem_wr.we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the access on acceptance and run the fill counter.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r      <= in_cmd;
      addr_r     <= in_address;
      wval_r     <= in_write_value;
      miss_r     <= !in_hit;
      fill_cnt_r <= '0;
    end else if (state_r == ST_FILL) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
      if (fill_cnt_r != '0 && fill_prev[WORD_W-1:0] == cur_word) begin
        fill_word_r <= mem_rdata;
      end
    end
  end

  // Valid bits and tags, updated when a fill completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == ST_FILL && fill_last) begin
      valid_r[cur_line] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FILL && fill_last) begin
      tag_r[cur_line] <= cur_tag;
    end
  end

  // Cache data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cache_rdata_r <= cache_mem[cache_raddr];
  end

  // Output register; a write returns its own value, a read the cached word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_go) begin
      out_miss_r <= miss_r;
      out_addr_r <= addr_r;
      if (cmd_r == CMD_WRITE) begin
        out_data_r <= wval_r;
      end else if (miss_r) begin
        out_data_r <= fill_word_r;
      end else begin
        out_data_r <= cache_rdata_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_miss       = out_miss_r;
  assign out_word_index = out_addr_r[WORD_W-1:0];
  assign out_line_index = out_addr_r[SLOT_W-1:WORD_W];
  assign out_tag_out    = out_addr_r[ADDR_W-1:SLOT_W];
  assign out_data_out   = out_data_r;

endmodule
